// ===== rtl/bitmap_page_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Shorthand for the clocked, reset-qualified checks in the allocator.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Sizes, request kinds and the scan unit result shared by the allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAX_PAGES  = 4096;
   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(WORD_COUNT);
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int PAGE_W     = 12;
   localparam int RANGE_W    = 13;
   localparam int MODE_W     = 2;
   // Word counter wide enough to hold the word count itself.
   localparam int WCNT_W     = RANGE_W - BIT_IDX_W;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic                 found;     // a free page below the limit exists
      logic [BIT_IDX_W-1:0] free_bit;  // lowest such page within the word
      logic                 page_used; // state of the addressed page
      word_type             new_word;  // word with the update applied
   } scan_result_type;

endpackage

// ===== rtl/bpa_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator word store
// One read and one write port over the usage bitmap, with per-word valid bits.
// ----------------------------------------------------------------------------
module bpa_bitmap_mem (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [bpa_pkg::WORD_IDX_W-1:0]  rd_addr,
   output bpa_pkg::word_type               rd_data,
   input  logic                            wr_en,
   input  logic [bpa_pkg::WORD_IDX_W-1:0]  wr_addr,
   input  bpa_pkg::word_type               wr_data
);
   import bpa_pkg::*;

   word_type              mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;
   word_type              rd_q_ff;
   logic                  rd_valid_ff;

   // A word never written since reset reads as all pages used.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '1;

endmodule

// ===== rtl/bpa_word_scan.sv =====
// ----------------------------------------------------------------------------
// Bitmap page allocator word scan unit
// Finds the lowest free page of one word below the limit and builds updates.
// ----------------------------------------------------------------------------
module bpa_word_scan (
   input  bpa_pkg::word_type                 word_data,
   input  logic [bpa_pkg::WORD_IDX_W-1:0]    word_idx,
   input  logic [bpa_pkg::RANGE_W-1:0]       limit,
   input  logic [bpa_pkg::MODE_W-1:0]        mode,
   input  logic [bpa_pkg::BIT_IDX_W-1:0]     page_bit,
   output bpa_pkg::scan_result_type          result
);
   import bpa_pkg::*;

   logic [WCNT_W-1:0]    lim_word;
   logic [BIT_IDX_W-1:0] lim_bit;
   word_type             in_limit;
   word_type             avail;
   logic [BIT_IDX_W-1:0] pos;
   logic [BIT_IDX_W-1:0] sel_bit;
   word_type             sel_mask;

   assign lim_word = limit[RANGE_W-1:BIT_IDX_W];
   assign lim_bit  = limit[BIT_IDX_W-1:0];

   // Pages of this word that lie below the search limit.
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         if ({1'b0, word_idx} < lim_word) begin
            in_limit[b] = 1'b1;
         end else if ({1'b0, word_idx} == lim_word) begin
            in_limit[b] = BIT_IDX_W'(b) < lim_bit;
         end else begin
            in_limit[b] = 1'b0;
         end
      end
   end

   assign avail = ~word_data & in_limit;

   // Priority encoder: the lowest available bit wins.
   always_comb begin
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            pos = BIT_IDX_W'(b);
         end
      end
   end

   assign sel_bit  = (mode == MODE_ALLOC) ? pos : page_bit;
   assign sel_mask = word_type'(1) << sel_bit;

   always_comb begin
      result.found     = |avail;
      result.free_bit  = pos;
      result.page_used = word_data[page_bit];
      case (mode)
         MODE_FREE: begin
            result.new_word = word_data & ~sel_mask;
         end
         MODE_ALLOC, MODE_MARK: begin
            result.new_word = word_data | sel_mask;
         end
         default: begin
            result.new_word = word_data;
         end
      endcase
   end

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// Allocate scans the bitmap words in range, up to 64, for the lowest free page;
// free, mark-used and query examine only the addressed word.
// One request at a time; the word store's single read port and the scan unit
// examine one 64-page word per cycle during an allocation scan.
// Reset: synchronous, active high; every page reads as used, search range 4096.
// ----------------------------------------------------------------------------
// Bitmap page allocator, first fit
// Sequencer over a 64 x 64-bit usage bitmap and a shared word scan unit.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_assert.svh"

module bitmap_page_allocator (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] page_number, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] result_page, [15:12] zero
   output logic        rsp_tuser,   // [0] success
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bpa_pkg::*;

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]            state_ff,       state_in;
   logic [MODE_W-1:0]     mode_ff,        mode_in;
   logic [PAGE_W-1:0]     page_ff,        page_in;
   logic [WORD_IDX_W-1:0] word_ff,        word_in;
   logic [PAGE_W-1:0]     result_page_ff, result_page_in;
   logic                  success_ff,     success_in;
   logic                  rsp_valid_ff,   rsp_valid_in;
   logic [PAGE_W-1:0]     rsp_page_ff,    rsp_page_in;
   logic                  rsp_success_ff, rsp_success_in;
   logic [RANGE_W-1:0]    range_ff,       range_in;

   logic [RANGE_W-1:0]    limit;
   logic [WCNT_W-1:0]     word_total;
   logic                  last_word;
   logic                  req_accept;
   logic                  rsp_load;
   logic                  csr_write;

   logic                  rd_en;
   logic [WORD_IDX_W-1:0] rd_addr;
   word_type              rd_data;
   logic                  wr_en;

   scan_result_type       scan;

   // ------------------------------------------------------------------------
   // Configuration. The search range is the only register; it is written at
   // the access phase of an APB write and reads back zero-extended.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      range_in = range_ff;
      if (csr_write && !csr_paddr[2]) begin
         range_in = csr_pwdata[RANGE_W-1:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32 - RANGE_W){1'b0}}, range_ff};

   // The search is clamped to the bitmap capacity, which is also the count of
   // page numbers a response can carry. The word count rounds up so that a
   // partial last word is still examined.
   assign limit      = (range_ff > RANGE_W'(MAX_PAGES)) ? RANGE_W'(MAX_PAGES) : range_ff;
   assign word_total = limit[RANGE_W-1:BIT_IDX_W]
                     + WCNT_W'(|limit[BIT_IDX_W-1:0]);
   assign last_word  = (WCNT_W'(word_ff) + WCNT_W'(1)) == word_total;

   // ------------------------------------------------------------------------
   // Shared parts: the bitmap word store and the word scan unit.
   // ------------------------------------------------------------------------
   bpa_bitmap_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (scan.new_word)
   );

   bpa_word_scan u_scan (
      .word_data (rd_data),
      .word_idx  (word_ff),
      .limit     (limit),
      .mode      (mode_ff),
      .page_bit  (page_ff[BIT_IDX_W-1:0]),
      .result    (scan)
   );

   // ------------------------------------------------------------------------
   // Sequencer. A request is taken only in idle. The addressed word is read in
   // the read state and its data is examined in the check state. During an
   // allocation scan the next word is fetched while the current one is
   // examined, so the scan moves one word per cycle. The result then waits
   // in the done state until the response register is free.
   // ------------------------------------------------------------------------
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rd_en = 1'b0;
      rd_addr = word_ff;
      if (state_ff == S_READ) begin
         rd_en = 1'b1;
      end else if (state_ff == S_CHECK && mode_ff == MODE_ALLOC && !scan.found &&
                   !last_word) begin
         rd_en   = 1'b1;
         rd_addr = word_ff + WORD_IDX_W'(1);
      end
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      page_in        = page_ff;
      word_in        = word_ff;
      result_page_in = result_page_ff;
      success_in     = success_ff;
      wr_en          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mode_in = req_tuser;
               page_in = req_tdata[PAGE_W-1:0];
               if (req_tuser == MODE_ALLOC) begin
                  word_in = '0;
                  if (word_total == '0) begin
                     // Empty search range: the allocation fails at once.
                     result_page_in = '0;
                     success_in     = 1'b0;
                     state_in       = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  word_in  = req_tdata[PAGE_W-1:BIT_IDX_W];
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            result_page_in = page_ff;
            case (mode_ff)
               MODE_ALLOC: begin
                  if (scan.found) begin
                     wr_en          = 1'b1;
                     result_page_in = {word_ff, scan.free_bit};
                     success_in     = 1'b1;
                     state_in       = S_DONE;
                  end else if (last_word) begin
                     result_page_in = '0;
                     success_in     = 1'b0;
                     state_in       = S_DONE;
                  end else begin
                     word_in = word_ff + WORD_IDX_W'(1);
                  end
               end
               MODE_FREE, MODE_MARK: begin
                  wr_en      = 1'b1;
                  success_in = 1'b1;
                  state_in   = S_DONE;
               end
               default: begin
                  success_in = !scan.page_used;
                  state_in   = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Response register. It holds a finished result until the consumer takes
   // it, while the sequencer is already free for the next request.
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_page_in    = rsp_page_ff;
      rsp_success_in = rsp_success_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_page_in    = result_page_ff;
         rsp_success_in = success_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - PAGE_W){1'b0}}, rsp_page_ff};
   assign rsp_tuser  = rsp_success_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         range_ff     <= RANGE_W'(MAX_PAGES);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         range_ff     <= range_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      page_ff        <= page_in;
      word_ff        <= word_in;
      result_page_ff <= result_page_in;
      success_ff     <= success_in;
      rsp_page_ff    <= rsp_page_in;
      rsp_success_ff <= rsp_success_in;
   end

   // ------------------------------------------------------------------------
   // Checks on the sequencer.
   // ------------------------------------------------------------------------
   `BPA_ASSERT_NEXT(a_accept_leaves_idle, req_accept, state_ff != S_IDLE, "request taken but sequencer stayed idle")
   `BPA_ASSERT_SAME(a_scan_in_range, (state_ff == S_CHECK) && (mode_ff == MODE_ALLOC), WCNT_W'(word_ff) < word_total, "allocation scan ran past the search range")
   `BPA_ASSERT_NEXT(a_alloc_below_limit, (state_ff == S_CHECK) && (mode_ff == MODE_ALLOC) && scan.found, (RANGE_W'(result_page_ff) < limit) && success_ff, "allocated page lies outside the search range")

endmodule
